/* sv/weighted_worker_load_balancer_unit_macros.svh */
// assertion macros for the weighted worker load balancer checker
// no dependencies; clk_i and rst_ni must be visible where used
`ifndef WEIGHTED_WORKER_LOAD_BALANCER_UNIT_MACROS_SVH
`define WEIGHTED_WORKER_LOAD_BALANCER_UNIT_MACROS_SVH

// same-cycle implication
`define WWLB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wwlb check failed");

// next-cycle implication
`define WWLB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wwlb check failed");

`endif

/* sv/wwlb_pkg.sv */
// shared constants, op codes and control structs for the load balancer
// no dependencies
package wwlb_pkg;

  localparam int NumWorkers = 8;
  localparam int IdxW       = 3;
  localparam int NumW       = 4;
  localparam int DivW       = 32;
  localparam int DivStepW   = 5;

  localparam logic [1:0] CMD_ATTACH = 2'd0;
  localparam logic [1:0] CMD_DETACH = 2'd1;
  localparam logic [1:0] CMD_PUT    = 2'd2;

  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_DECODE   = 4'd2;
  localparam logic [3:0] OP_ATT_SCAN = 4'd3;
  localparam logic [3:0] OP_ATT_UPD  = 4'd4;
  localparam logic [3:0] OP_AVG_WR   = 4'd5;
  localparam logic [3:0] OP_DET_UPD  = 4'd6;
  localparam logic [3:0] OP_DET_SCAN = 4'd7;
  localparam logic [3:0] OP_DET_CRD  = 4'd8;
  localparam logic [3:0] OP_PUT_CHK  = 4'd9;
  localparam logic [3:0] OP_PUT_SCAN = 4'd10;
  localparam logic [3:0] OP_PUT_SRC  = 4'd11;
  localparam logic [3:0] OP_PUT_DST  = 4'd12;
  localparam logic [3:0] OP_PUT_STAY = 4'd13;
  localparam logic [3:0] OP_PUT_CRD  = 4'd14;

  typedef struct packed {
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       w_bad;
    logic       n_zero;
    logic       idx_end;
    logic       det_hit;
    logic       put_go;
    logic       put_move;
    logic       rb;
    logic       div_busy;
  } dp_sts_t;

endpackage

/* sv/wwlb_div.sv */
// iterative restoring divider, one quotient bit per cycle
// uses wwlb_pkg; a zero divisor yields a zero quotient
module wwlb_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [wwlb_pkg::DivW-1:0] num_i,
  input  logic [wwlb_pkg::DivW-1:0] den_i,
  output logic                     busy_o,
  output logic [wwlb_pkg::DivW-1:0] quo_o
);

  logic                          busy_q, busy_d;
  logic [wwlb_pkg::DivStepW-1:0] step_q, step_d;
  logic [wwlb_pkg::DivW-1:0]     rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic                          zero_q, zero_d;
  logic [wwlb_pkg::DivW:0]       rem_sh, diff;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    zero_d = zero_q;
    rem_sh = {rem_q, quo_q[wwlb_pkg::DivW-1]};
    diff   = rem_sh - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      zero_d = (den_i == '0);
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = diff[wwlb_pkg::DivW-1:0];
        quo_d = {quo_q[wwlb_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[wwlb_pkg::DivW-1:0];
        quo_d = {quo_q[wwlb_pkg::DivW-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == '1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    zero_q <= zero_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = zero_q ? '0 : quo_q;

endmodule

/* sv/wwlb_dp.sv */
// datapath: per-worker tables, scan index, task registers and the divider
// uses wwlb_pkg and wwlb_div; driven by ops from wwlb_ctrl
module wwlb_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wwlb_pkg::dp_cmd_t cmd_i,
  output wwlb_pkg::dp_sts_t sts_o,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  input  logic [1:0]        command_i,
  input  logic [2:0]        worker_i,
  input  logic [15:0]       task_weight_i,
  input  logic [15:0]       task_smooth_weight_i,
  input  logic [15:0]       new_smooth_weight_i,
  input  logic              task_rebalance_i,
  output logic              status_o,
  output logic [2:0]        target_worker_o,
  output logic              moved_o,
  output logic [15:0]       task_weight_out_o,
  output logic [15:0]       task_smooth_weight_out_o,
  output logic              task_rebalance_out_o
);

  localparam int IW = wwlb_pkg::IdxW;
  localparam int NW = wwlb_pkg::NumW;

  logic [31:0] tot_q [wwlb_pkg::NumWorkers];
  logic [15:0] cnt_q [wwlb_pkg::NumWorkers];
  logic [31:0] avg_q [wwlb_pkg::NumWorkers];
  logic [15:0] crd_q [wwlb_pkg::NumWorkers];
  logic [3:0]  act_q;

  logic [1:0]    cmd_q;
  logic [IW-1:0] w_q, best_q, aidx_q, target_q;
  logic [15:0]   wt_q, sw_q, nsw_q;
  logic          rb_q, status_q, moved_q;
  logic [32:0]   best_tot_q;
  logic [31:0]   wtot_q;
  logic [NW-1:0] idx_q;

  logic [NW-1:0] n;
  logic [IW-1:0] rd_addr;
  logic [31:0]   rd_tot, rd_avg;
  logic [15:0]   rd_cnt, rd_crd;
  logic          div_start, div_busy;
  logic [31:0]   div_num, div_den, div_quo;
  logic [16:0]   delta;
  logic [32:0]   sum_scan, need, crd_sum;
  logic [31:0]   rb_tot;

  assign n = (act_q > 4'(wwlb_pkg::NumWorkers)) ? NW'(wwlb_pkg::NumWorkers) : act_q;

  always_comb begin
    case (cmd_i.op)
      wwlb_pkg::OP_ATT_SCAN, wwlb_pkg::OP_DET_SCAN,
      wwlb_pkg::OP_DET_CRD, wwlb_pkg::OP_PUT_SCAN: rd_addr = idx_q[IW-1:0];
      wwlb_pkg::OP_ATT_UPD, wwlb_pkg::OP_PUT_DST:  rd_addr = best_q;
      default:                                     rd_addr = w_q;
    endcase
  end

  assign rd_tot = tot_q[rd_addr];
  assign rd_cnt = cnt_q[rd_addr];
  assign rd_avg = avg_q[rd_addr];
  assign rd_crd = crd_q[rd_addr];

  assign delta    = (nsw_q > wt_q) ? {1'b0, nsw_q} - {1'b0, wt_q}
                                   : {1'b0, wt_q} - {1'b0, nsw_q};
  assign sum_scan = {17'd0, wt_q} + {1'b0, rd_tot};
  assign need     = {1'b0, rd_avg} + {1'b0, wtot_q};
  assign crd_sum  = {17'd0, rd_crd} + {1'b0, div_quo};
  assign rb_tot   = rd_tot - {16'd0, wt_q} + {16'd0, sw_q};

  assign sts_o.cmd      = cmd_q;
  assign sts_o.w_bad    = ({1'b0, w_q} >= n);
  assign sts_o.n_zero   = (n == '0);
  assign sts_o.idx_end  = (idx_q >= n);
  assign sts_o.det_hit  = (rd_addr != w_q) && (rd_avg != '0) && ({1'b0, rd_tot} >= need);
  assign sts_o.put_go   = (rd_crd != '0) || rb_q;
  assign sts_o.put_move = (best_q != w_q);
  assign sts_o.rb       = rb_q;
  assign sts_o.div_busy = div_busy;

  always_comb begin
    div_start = 1'b0;
    div_num   = rd_tot;
    div_den   = {16'd0, rd_cnt};
    case (cmd_i.op)
      wwlb_pkg::OP_ATT_UPD: begin
        div_start = 1'b1;
        div_num   = rd_tot + {16'd0, wt_q};
        div_den   = {16'd0, rd_cnt + 16'd1};
      end
      wwlb_pkg::OP_DET_UPD, wwlb_pkg::OP_PUT_SRC: begin
        div_start = 1'b1;
        div_num   = rd_tot - {16'd0, wt_q};
        div_den   = {16'd0, rd_cnt - 16'd1};
      end
      wwlb_pkg::OP_DET_SCAN: begin
        div_start = !sts_o.idx_end && sts_o.det_hit;
        div_num   = rd_tot - wtot_q;
        div_den   = rd_avg;
      end
      wwlb_pkg::OP_PUT_DST: begin
        div_start = 1'b1;
        div_num   = best_tot_q[31:0];
        div_den   = {16'd0, rd_cnt + 16'd1};
      end
      wwlb_pkg::OP_PUT_STAY: begin
        div_start = rb_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  wwlb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // worker tables and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wwlb_pkg::NumWorkers; i++) begin
        tot_q[i] <= '0;
        cnt_q[i] <= '0;
        avg_q[i] <= '0;
        crd_q[i] <= '0;
      end
      act_q <= 4'd1;
    end else begin
      if (cfg_we_i) begin
        act_q <= cfg_wdata_i;
      end
      case (cmd_i.op)
        wwlb_pkg::OP_ATT_UPD: begin
          tot_q[rd_addr] <= rd_tot + {16'd0, wt_q};
          cnt_q[rd_addr] <= rd_cnt + 16'd1;
        end
        wwlb_pkg::OP_AVG_WR: begin
          avg_q[aidx_q] <= div_quo;
        end
        wwlb_pkg::OP_DET_UPD: begin
          tot_q[rd_addr] <= rd_tot - {16'd0, wt_q};
          cnt_q[rd_addr] <= rd_cnt - 16'd1;
        end
        wwlb_pkg::OP_DET_CRD: begin
          crd_q[rd_addr] <= (crd_sum >= {17'd0, rd_cnt}) ? rd_cnt : crd_sum[15:0];
        end
        wwlb_pkg::OP_PUT_CHK: begin
          if (rb_q && sts_o.put_go) begin
            tot_q[rd_addr] <= rb_tot;
          end
        end
        wwlb_pkg::OP_PUT_SRC: begin
          tot_q[rd_addr] <= rd_tot - {16'd0, wt_q};
          cnt_q[rd_addr] <= rd_cnt - 16'd1;
          if (rd_crd != '0) begin
            crd_q[rd_addr] <= rd_crd - 16'd1;
          end
        end
        wwlb_pkg::OP_PUT_DST: begin
          tot_q[rd_addr] <= best_tot_q[31:0];
          cnt_q[rd_addr] <= rd_cnt + 16'd1;
        end
        wwlb_pkg::OP_PUT_CRD: begin
          if ({16'd0, wt_q} <= rd_avg) begin
            crd_q[rd_addr] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // task and scan registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      wwlb_pkg::OP_LOAD: begin
        cmd_q <= command_i;
        w_q   <= worker_i;
        wt_q  <= task_weight_i;
        sw_q  <= task_smooth_weight_i;
        nsw_q <= new_smooth_weight_i;
        rb_q  <= task_rebalance_i;
      end
      wwlb_pkg::OP_DECODE: begin
        status_q   <= ((cmd_q == wwlb_pkg::CMD_ATTACH) && sts_o.n_zero) ||
                      ((cmd_q == wwlb_pkg::CMD_DETACH || cmd_q == wwlb_pkg::CMD_PUT) &&
                       sts_o.w_bad);
        target_q   <= (cmd_q == wwlb_pkg::CMD_ATTACH) ? '0 : w_q;
        moved_q    <= 1'b0;
        best_q     <= '0;
        best_tot_q <= '1;
        idx_q      <= '0;
        wtot_q     <= rd_tot;
        if (cmd_q == wwlb_pkg::CMD_PUT && !sts_o.w_bad && sw_q != nsw_q) begin
          sw_q <= nsw_q;
          rb_q <= (delta >= {4'd0, wt_q[15:3]});
        end
      end
      wwlb_pkg::OP_ATT_SCAN: begin
        if (!sts_o.idx_end) begin
          if ({1'b0, rd_tot} < best_tot_q) begin
            best_q     <= rd_addr;
            best_tot_q <= {1'b0, rd_tot};
          end
          idx_q <= idx_q + 1'b1;
        end
      end
      wwlb_pkg::OP_ATT_UPD: begin
        target_q <= rd_addr;
        aidx_q   <= rd_addr;
      end
      wwlb_pkg::OP_DET_UPD: begin
        wtot_q <= rd_tot - {16'd0, wt_q};
        aidx_q <= rd_addr;
      end
      wwlb_pkg::OP_DET_SCAN: begin
        if (!sts_o.idx_end && !sts_o.det_hit) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      wwlb_pkg::OP_DET_CRD: begin
        idx_q <= idx_q + 1'b1;
      end
      wwlb_pkg::OP_PUT_CHK: begin
        best_q <= w_q;
        idx_q  <= '0;
        if (rb_q) begin
          wt_q       <= sw_q;
          wtot_q     <= rb_tot;
          best_tot_q <= {1'b0, rb_tot};
        end else begin
          best_tot_q <= {1'b0, rd_tot};
        end
      end
      wwlb_pkg::OP_PUT_SCAN: begin
        if (!sts_o.idx_end) begin
          if (rd_addr != w_q && sum_scan < best_tot_q) begin
            best_q     <= rd_addr;
            best_tot_q <= sum_scan;
          end
          idx_q <= idx_q + 1'b1;
        end
      end
      wwlb_pkg::OP_PUT_SRC: begin
        aidx_q   <= rd_addr;
        rb_q     <= 1'b0;
        target_q <= best_q;
        moved_q  <= 1'b1;
      end
      wwlb_pkg::OP_PUT_DST: begin
        aidx_q <= rd_addr;
      end
      wwlb_pkg::OP_PUT_STAY: begin
        aidx_q <= rd_addr;
        rb_q   <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign status_o                 = status_q;
  assign target_worker_o          = target_q;
  assign moved_o                  = moved_q;
  assign task_weight_out_o        = wt_q;
  assign task_smooth_weight_out_o = sw_q;
  assign task_rebalance_out_o     = rb_q;

endmodule

/* sv/wwlb_ctrl.sv */
// controller: sequences scans, table updates and divides for one beat
// uses wwlb_pkg; talks to wwlb_dp through dp_cmd_t and dp_sts_t
module wwlb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wwlb_pkg::dp_cmd_t cmd_o,
  input  wwlb_pkg::dp_sts_t sts_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DEC      = 4'd1;
  localparam logic [3:0] S_ATT_SCAN = 4'd2;
  localparam logic [3:0] S_ATT_UPD  = 4'd3;
  localparam logic [3:0] S_WAIT     = 4'd4;
  localparam logic [3:0] S_WAIT_AMT = 4'd5;
  localparam logic [3:0] S_DET_UPD  = 4'd6;
  localparam logic [3:0] S_DET_SCAN = 4'd7;
  localparam logic [3:0] S_DET_CRD  = 4'd8;
  localparam logic [3:0] S_PUT_CHK  = 4'd9;
  localparam logic [3:0] S_PUT_SCAN = 4'd10;
  localparam logic [3:0] S_PUT_SRC  = 4'd11;
  localparam logic [3:0] S_PUT_DST  = 4'd12;
  localparam logic [3:0] S_PUT_STAY = 4'd13;
  localparam logic [3:0] S_PUT_CRD  = 4'd14;
  localparam logic [3:0] S_OUT      = 4'd15;

  logic [3:0] state_q, state_d, ret_q, ret_d;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cmd_o.op  = wwlb_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = wwlb_pkg::OP_LOAD;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.op = wwlb_pkg::OP_DECODE;
        case (sts_i.cmd)
          wwlb_pkg::CMD_ATTACH: state_d = sts_i.n_zero ? S_OUT : S_ATT_SCAN;
          wwlb_pkg::CMD_DETACH: state_d = sts_i.w_bad ? S_OUT : S_DET_UPD;
          wwlb_pkg::CMD_PUT:    state_d = sts_i.w_bad ? S_OUT : S_PUT_CHK;
          default:              state_d = S_OUT;
        endcase
      end
      S_ATT_SCAN: begin
        cmd_o.op = wwlb_pkg::OP_ATT_SCAN;
        if (sts_i.idx_end) begin
          state_d = S_ATT_UPD;
        end
      end
      S_ATT_UPD: begin
        cmd_o.op = wwlb_pkg::OP_ATT_UPD;
        ret_d    = S_OUT;
        state_d  = S_WAIT;
      end
      S_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = wwlb_pkg::OP_AVG_WR;
          state_d  = ret_q;
        end
      end
      S_WAIT_AMT: begin
        if (!sts_i.div_busy) begin
          state_d = S_DET_CRD;
        end
      end
      S_DET_UPD: begin
        cmd_o.op = wwlb_pkg::OP_DET_UPD;
        ret_d    = S_DET_SCAN;
        state_d  = S_WAIT;
      end
      S_DET_SCAN: begin
        cmd_o.op = wwlb_pkg::OP_DET_SCAN;
        if (sts_i.idx_end) begin
          state_d = S_OUT;
        end else if (sts_i.det_hit) begin
          state_d = S_WAIT_AMT;
        end
      end
      S_DET_CRD: begin
        cmd_o.op = wwlb_pkg::OP_DET_CRD;
        state_d  = S_DET_SCAN;
      end
      S_PUT_CHK: begin
        cmd_o.op = wwlb_pkg::OP_PUT_CHK;
        state_d  = sts_i.put_go ? S_PUT_SCAN : S_OUT;
      end
      S_PUT_SCAN: begin
        cmd_o.op = wwlb_pkg::OP_PUT_SCAN;
        if (sts_i.idx_end) begin
          state_d = sts_i.put_move ? S_PUT_SRC : S_PUT_STAY;
        end
      end
      S_PUT_SRC: begin
        cmd_o.op = wwlb_pkg::OP_PUT_SRC;
        ret_d    = S_PUT_DST;
        state_d  = S_WAIT;
      end
      S_PUT_DST: begin
        cmd_o.op = wwlb_pkg::OP_PUT_DST;
        ret_d    = S_OUT;
        state_d  = S_WAIT;
      end
      S_PUT_STAY: begin
        cmd_o.op = wwlb_pkg::OP_PUT_STAY;
        ret_d    = S_PUT_CRD;
        state_d  = sts_i.rb ? S_WAIT : S_PUT_CRD;
      end
      S_PUT_CRD: begin
        cmd_o.op = wwlb_pkg::OP_PUT_CRD;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_OUT;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

/* sv/weighted_worker_load_balancer_unit.sv */
// top level of the weighted worker load balancer
// uses wwlb_pkg, wwlb_ctrl, wwlb_dp (with wwlb_div)
//
//   channel   handshake               payload
//   input     in_valid_i / in_stall_o  command, worker, task fields
//   output    out_valid_o / out_stall_i status, target, moved, task fields
//   config    cfg_we_i                 cfg_wdata_i (active_workers)
//
// one beat at a time; detach waits on one more divide per credited worker
// each average or credit amount uses the shared divider
// reset clears all worker tables and sets active_workers to 1
// in_stall_o is high from accept until the result beat is taken
module weighted_worker_load_balancer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [2:0]  worker_i,
  input  logic [15:0] task_weight_i,
  input  logic [15:0] task_smooth_weight_i,
  input  logic [15:0] new_smooth_weight_i,
  input  logic        task_rebalance_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [2:0]  target_worker_o,
  output logic        moved_o,
  output logic [15:0] task_weight_out_o,
  output logic [15:0] task_smooth_weight_out_o,
  output logic        task_rebalance_out_o
);

  wwlb_pkg::dp_cmd_t dp_cmd;
  wwlb_pkg::dp_sts_t dp_sts;

  wwlb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd),
    .sts_i       (dp_sts)
  );

  wwlb_dp u_dp (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cmd_i                    (dp_cmd),
    .sts_o                    (dp_sts),
    .cfg_we_i                 (cfg_we_i),
    .cfg_wdata_i              (cfg_wdata_i),
    .command_i                (command_i),
    .worker_i                 (worker_i),
    .task_weight_i            (task_weight_i),
    .task_smooth_weight_i     (task_smooth_weight_i),
    .new_smooth_weight_i      (new_smooth_weight_i),
    .task_rebalance_i         (task_rebalance_i),
    .status_o                 (status_o),
    .target_worker_o          (target_worker_o),
    .moved_o                  (moved_o),
    .task_weight_out_o        (task_weight_out_o),
    .task_smooth_weight_out_o (task_smooth_weight_out_o),
    .task_rebalance_out_o     (task_rebalance_out_o)
  );

endmodule

/* sv/wwlb_chk.sv */
// port-level checker for the load balancer, bound to the top level
// uses weighted_worker_load_balancer_unit_macros.svh
`include "weighted_worker_load_balancer_unit_macros.svh"

module wwlb_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        status_o,
  input logic [2:0]  target_worker_o,
  input logic        moved_o
);

  `WWLB_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `WWLB_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(target_worker_o))
  `WWLB_ASSERT_NXT(a_no_same_beat, in_valid_i && !in_stall_o, !out_valid_o && in_stall_o)
  `WWLB_ASSERT_IMP(a_one_at_time, out_valid_o, in_stall_o)
  `WWLB_ASSERT_IMP(a_move_ok, out_valid_o && moved_o, !status_o)

endmodule

bind weighted_worker_load_balancer_unit wwlb_chk u_wwlb_chk (.*);

/* sim/tb_weighted_worker_load_balancer_unit.sv */
// self-checking testbench for the weighted worker load balancer unit
// depends on wwlb_pkg and weighted_worker_load_balancer_unit; predicts each beat in-line
module tb_weighted_worker_load_balancer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  worker;
    logic [15:0] weight;
    logic [15:0] smooth;
    logic [15:0] new_smooth;
    logic        rebal;
  } task_req_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  target;
    logic        moved;
    logic [15:0] weight;
    logic [15:0] smooth;
    logic        rebal;
  } task_resp_t;

  typedef struct {
    task_req_t req;
    logic      known;
    task_resp_t resp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = 4'd0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] command_i = '0;
  logic [2:0] worker_i = '0;
  logic [15:0] task_weight_i = '0;
  logic [15:0] task_smooth_weight_i = '0;
  logic [15:0] new_smooth_weight_i = '0;
  logic task_rebalance_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic status_o;
  logic [2:0] target_worker_o;
  logic moved_o;
  logic [15:0] task_weight_out_o;
  logic [15:0] task_smooth_weight_out_o;
  logic task_rebalance_out_o;

  weighted_worker_load_balancer_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .command_i, .worker_i, .task_weight_i, .task_smooth_weight_i,
    .new_smooth_weight_i, .task_rebalance_i, .out_valid_o, .out_stall_i,
    .status_o, .target_worker_o, .moved_o, .task_weight_out_o,
    .task_smooth_weight_out_o, .task_rebalance_out_o
  );

  logic [31:0] load_total [wwlb_pkg::NumWorkers];
  logic [15:0] load_tasks [wwlb_pkg::NumWorkers];
  logic [31:0] load_avg   [wwlb_pkg::NumWorkers];
  logic [15:0] load_credit[wwlb_pkg::NumWorkers];
  logic [3:0]  live_workers;

  task_resp_t pending_resp[$];
  logic       pending_known[$];
  task_resp_t pending_typed[$];
  int errors = 0;
  bit hold_off = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [31:0] mean_of(logic [31:0] tot, logic [15:0] cnt);
    return (cnt == 0) ? 32'd0 : tot / {16'd0, cnt};
  endfunction

  function automatic task_resp_t balance_step(task_req_t r);
    task_resp_t o;
    int n, best;
    logic [31:0] wt, sw;
    logic rb;
    logic [63:0] need, amount, c, best_total, t;
    n = (live_workers > wwlb_pkg::NumWorkers) ? wwlb_pkg::NumWorkers : live_workers;
    wt = {16'd0, r.weight};
    sw = {16'd0, r.smooth};
    rb = r.rebal;
    o.status = 1'b0;
    o.target = r.worker;
    o.moved = 1'b0;
    if (r.command == wwlb_pkg::CMD_ATTACH) begin
      if (n == 0) begin
        o.status = 1'b1;
        o.target = 3'd0;
      end else begin
        best = 0;
        for (int i = 1; i < n; i++)
          if (load_total[i] < load_total[best]) best = i;
        load_total[best] += wt;
        load_tasks[best] += 16'd1;
        load_avg[best] = mean_of(load_total[best], load_tasks[best]);
        o.target = best[2:0];
      end
    end else if (r.command == wwlb_pkg::CMD_DETACH) begin
      if (r.worker >= n) o.status = 1'b1;
      else begin
        load_total[r.worker] -= wt;
        load_tasks[r.worker] -= 16'd1;
        load_avg[r.worker] = mean_of(load_total[r.worker], load_tasks[r.worker]);
        for (int i = 0; i < n; i++) begin
          if (i == r.worker || load_avg[i] == 0) continue;
          need = {32'd0, load_avg[i]} + {32'd0, load_total[r.worker]};
          if ({32'd0, load_total[i]} >= need) begin
            amount = ({32'd0, load_total[i]} - {32'd0, load_total[r.worker]})
                     / {32'd0, load_avg[i]};
            c = {48'd0, load_credit[i]} + amount;
            if (c >= {48'd0, load_tasks[i]}) c = {48'd0, load_tasks[i]};
            load_credit[i] = c[15:0];
          end
        end
      end
    end else if (r.command == wwlb_pkg::CMD_PUT) begin
      if (r.worker >= n) o.status = 1'b1;
      else begin
        if (r.smooth != r.new_smooth) begin
          logic [31:0] delta;
          delta = (r.new_smooth > wt) ? r.new_smooth - wt : wt - r.new_smooth;
          sw = {16'd0, r.new_smooth};
          rb = (delta >= (wt >> 3));
        end
        if (load_credit[r.worker] != 0 || rb) begin
          best = r.worker;
          if (rb) begin
            load_total[r.worker] -= wt;
            wt = sw;
            load_total[r.worker] += wt;
          end
          best_total = {32'd0, load_total[r.worker]};
          for (int i = 0; i < n; i++) begin
            t = {32'd0, wt} + {32'd0, load_total[i]};
            if (i != r.worker && t < best_total) begin
              best = i;
              best_total = t;
            end
          end
          if (best != r.worker) begin
            load_total[r.worker] -= wt;
            load_tasks[r.worker] -= 16'd1;
            load_avg[r.worker] = mean_of(load_total[r.worker], load_tasks[r.worker]);
            load_tasks[best] += 16'd1;
            load_total[best] = best_total[31:0];
            load_avg[best] = mean_of(load_total[best], load_tasks[best]);
            rb = 1'b0;
            if (load_credit[r.worker] != 0) load_credit[r.worker] -= 16'd1;
            o.target = best[2:0];
            o.moved = 1'b1;
          end else begin
            if (rb) begin
              rb = 1'b0;
              load_avg[r.worker] = mean_of(load_total[r.worker], load_tasks[r.worker]);
            end
            if (wt <= load_avg[r.worker]) load_credit[r.worker] = 16'd0;
          end
        end
      end
    end
    o.weight = wt[15:0];
    o.smooth = sw[15:0];
    o.rebal = rb;
    return o;
  endfunction

  // offer one beat, hold it until accepted
  task automatic send_beat(task_req_t r, logic known, task_resp_t typed);
    task_resp_t p;
    command_i <= r.command;
    worker_i <= r.worker;
    task_weight_i <= r.weight;
    task_smooth_weight_i <= r.smooth;
    new_smooth_weight_i <= r.new_smooth;
    task_rebalance_i <= r.rebal;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    p = balance_step(r);
    pending_resp.push_back(p);
    pending_known.push_back(known);
    pending_typed.push_back(typed);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_and_config(logic [3:0] v);
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    live_workers = v;
  endtask

  function automatic task_req_t rand_req();
    task_req_t r;
    int k;
    r.command = ($urandom_range(0, 19) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
    r.worker = ($urandom_range(0, 9) == 0) ? 3'($urandom) :
               3'($urandom_range(0, (live_workers > 1) ? live_workers - 1 : 0));
    k = $urandom_range(0, 9);
    r.weight = (k == 0) ? 16'hffff : (k < 5) ? 16'($urandom_range(0, 255)) : 16'($urandom);
    k = $urandom_range(0, 3);
    r.smooth = 16'($urandom);
    r.new_smooth = (k == 0) ? r.smooth :
                   (k == 1) ? r.weight + 16'($urandom_range(0, 40)) : 16'($urandom);
    r.rebal = 1'($urandom);
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_resp.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        task_resp_t e;
        task_resp_t typed;
        logic known;
        e = pending_resp.pop_front();
        known = pending_known.pop_front();
        typed = pending_typed.pop_front();
        if (known) e = typed;
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); errors++;
        end
        if (target_worker_o !== e.target) begin
          $error("target_worker exp %0d got %0d", e.target, target_worker_o); errors++;
        end
        if (moved_o !== e.moved) begin
          $error("moved exp %0d got %0d", e.moved, moved_o); errors++;
        end
        if (task_weight_out_o !== e.weight) begin
          $error("task_weight_out exp %0h got %0h", e.weight, task_weight_out_o); errors++;
        end
        if (task_smooth_weight_out_o !== e.smooth) begin
          $error("task_smooth_weight_out exp %0h got %0h", e.smooth,
                 task_smooth_weight_out_o);
          errors++;
        end
        if (task_rebalance_out_o !== e.rebal) begin
          $error("task_rebalance_out exp %0d got %0d", e.rebal, task_rebalance_out_o);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern with a long hold-off on request
  initial begin
    int mode;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        out_stall_i <= (mode == 0) ? 1'b0 : ($urandom_range(0, 2) == 0);
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t s;
    task_req_t r;
    task_resp_t z;
    logic [3:0] cfgs[6];
    cfgs = '{4'd8, 4'd0, 4'd3, 4'd15, 4'd5, 4'd8};
    for (int i = 0; i < wwlb_pkg::NumWorkers; i++) begin
      load_total[i] = 0; load_tasks[i] = 0; load_avg[i] = 0; load_credit[i] = 0;
    end
    live_workers = 4'd1;
    z = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, one worker after reset
    s.req = '{wwlb_pkg::CMD_ATTACH, 3'd0, 16'hffff, 16'h0000, 16'hffff, 1'b1};
    s.known = 1; s.resp = '{1'b0, 3'd0, 1'b0, 16'hffff, 16'h0000, 1'b1}; rows.push_back(s);
    s.req = '{wwlb_pkg::CMD_DETACH, 3'd7, 16'h1234, 16'h0001, 16'h0002, 1'b0};
    s.known = 1; s.resp = '{1'b1, 3'd7, 1'b0, 16'h1234, 16'h0001, 1'b0}; rows.push_back(s);
    s.req = '{wwlb_pkg::CMD_PUT, 3'd1, 16'h0010, 16'h0001, 16'h0100, 1'b1};
    s.known = 1; s.resp = '{1'b1, 3'd1, 1'b0, 16'h0010, 16'h0001, 1'b1}; rows.push_back(s);
    s.req = '{CMD_UNUSED, 3'd5, 16'habcd, 16'h5555, 16'haaaa, 1'b1};
    s.known = 1; s.resp = '{1'b0, 3'd5, 1'b0, 16'habcd, 16'h5555, 1'b1}; rows.push_back(s);
    s.req = '{wwlb_pkg::CMD_PUT, 3'd0, 16'h0100, 16'h0100, 16'h0100, 1'b0};
    s.known = 0; rows.push_back(s);
    s.req = '{wwlb_pkg::CMD_DETACH, 3'd0, 16'hffff, 16'h0000, 16'h0000, 1'b0};
    s.known = 0; rows.push_back(s);
    s.req = '{wwlb_pkg::CMD_DETACH, 3'd0, 16'h0001, 16'h0000, 16'h0000, 1'b0};
    s.known = 0; rows.push_back(s);
    foreach (rows[i]) send_beat(rows[i].req, rows[i].known, rows[i].resp);

    // four workers: attaches, detach credits, puts that move
    drain_and_config(4'd4);
    for (int i = 0; i < 14; i++) begin
      r = '{wwlb_pkg::CMD_ATTACH, 3'd0, 16'(100 * (i + 1)), 16'd0, 16'd0, 1'b0};
      send_beat(r, 1'b0, z);
    end
    send_beat('{wwlb_pkg::CMD_DETACH, 3'd0, 16'd100, 16'd0, 16'd0, 1'b0}, 1'b0, z);
    send_beat('{wwlb_pkg::CMD_PUT, 3'd1, 16'd200, 16'd7, 16'd7, 1'b0}, 1'b0, z);
    send_beat('{wwlb_pkg::CMD_PUT, 3'd2, 16'd800, 16'd800, 16'd10, 1'b0}, 1'b0, z);
    send_beat('{wwlb_pkg::CMD_PUT, 3'd3, 16'd800, 16'd800, 16'd801, 1'b1}, 1'b0, z);

    drain_and_config(4'd0);
    send_beat('{wwlb_pkg::CMD_ATTACH, 3'd2, 16'd5, 16'd6, 16'd7, 1'b1}, 1'b1,
              '{1'b1, 3'd0, 1'b0, 16'd5, 16'd6, 1'b1});

    foreach (cfgs[c]) begin
      drain_and_config(cfgs[c]);
      for (int k = 0; k < 275; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          int gap;
          gap = $urandom_range(1, 60);
          repeat (gap) @(posedge clk_i);
        end
        if (c == 2 && k == 100) hold_off = 1'b1;
        if (c == 3 && k == 150) while (pending_resp.size() != 0) @(posedge clk_i);
        send_beat(rand_req(), 1'b0, z);
      end
    end

    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
